/* hdl/cau_pkg.sv */
// Shared types and constants for the convolution accumulator unit.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int WIN_REG_W  = 6;
  localparam int LEN_W      = 24;
  localparam int MASK_W     = 31;
  localparam int HALF_W     = 64;
  // wide enough to hold any window size up to the largest supported window
  localparam int WIN_CMP_W  = 7;

  localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 6'd24;
  localparam logic [LEN_W-1:0]     LENGTH_RESET = 24'd1;
  localparam logic [WIN_CMP_W-1:0] WINDOW_MIN   = 7'd2;

  typedef enum logic {
    REG_WINDOW_SIZE   = 1'b0,
    REG_VECTOR_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [WIN_REG_W-1:0] window_size;
    logic [LEN_W-1:0]     vector_length;
  } cfg_t;

  typedef struct packed {
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo2;
    logic [HALF_W-1:0] hi2;
  } elem_t;

endpackage

`default_nettype wire

/* hdl/convolution_accumulator_unit.sv */
// Top level of the convolution accumulator unit: config port, window and result register.
`timescale 1ns / 1ps
`default_nettype none

// Streams vector elements and returns each one XORed with the pending sum for its
// position, while folding it forward into later positions selected by mask_bits and
// into the position one window ahead. One element is taken per clock cycle while the
// result register is free or being read; its result is registered at the transfer.
// The pending window is a shift register updated in the transfer cycle, so the next
// element can follow immediately. The result register accepts a new element while the
// held result is being taken, so throughput stays at one per cycle while results are taken.
module convolution_accumulator_unit #(
  parameter int MAX_WINDOW = 32,
  parameter int ELEM_BITS  = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cau_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cau_pkg::DATA_W-1:0]  pwdata,
  output logic      [cau_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        data_valid,
  output logic                             data_ready,
  input  wire logic [cau_pkg::HALF_W-1:0]  data_lo,
  input  wire logic [cau_pkg::HALF_W-1:0]  data_hi,
  input  wire logic [cau_pkg::HALF_W-1:0]  data2_lo,
  input  wire logic [cau_pkg::HALF_W-1:0]  data2_hi,
  input  wire logic [cau_pkg::MASK_W-1:0]  mask_bits,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic      [cau_pkg::HALF_W-1:0]  out_lo,
  output logic      [cau_pkg::HALF_W-1:0]  out_hi,
  output logic      [cau_pkg::HALF_W-1:0]  out2_lo,
  output logic      [cau_pkg::HALF_W-1:0]  out2_hi,
  output logic                             is_last
);
  import cau_pkg::*;

  cfg_t  cfg;
  elem_t elem;
  elem_t result;
  logic  last;
  logic  take;

  assign data_ready = !result_valid || result_ready;
  assign take       = data_valid && data_ready;

  assign elem.lo  = data_lo;
  assign elem.hi  = data_hi;
  assign elem.lo2 = data2_lo;
  assign elem.hi2 = data2_hi;

  cau_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cau_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .ELEM_BITS  (ELEM_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .elem      (elem),
    .mask_bits (mask_bits),
    .result    (result),
    .last      (last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_lo  <= result.lo;
      out_hi  <= result.hi;
      out2_lo <= result.lo2;
      out2_hi <= result.hi2;
      is_last <= last;
    end
  end

endmodule

`default_nettype wire

/* hdl/cau_cfg.sv */
// APB register block holding window size and vector length.
`timescale 1ns / 1ps
`default_nettype none

module cau_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cau_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cau_pkg::DATA_W-1:0]  pwdata,
  output logic      [cau_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output cau_pkg::cfg_t                    cfg
);
  import cau_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  // registers sit on 4-byte boundaries; low address bits are ignored
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size   <= WINDOW_RESET;
      cfg.vector_length <= LENGTH_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW_SIZE:   cfg.window_size   <= pwdata[WIN_REG_W-1:0];
        REG_VECTOR_LENGTH: cfg.vector_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_WINDOW_SIZE:   prdata = DATA_W'(cfg.window_size);
      REG_VECTOR_LENGTH: prdata = DATA_W'(cfg.vector_length);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/cau_window.sv */
// Pending-sum shift window, position counter and per-element result logic.
`timescale 1ns / 1ps
`default_nettype none

module cau_window #(
  parameter int MAX_WINDOW = 32,
  parameter int ELEM_BITS  = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cau_pkg::cfg_t               cfg,
  input  wire logic                        take,
  input  wire cau_pkg::elem_t              elem,
  input  wire logic [cau_pkg::MASK_W-1:0]  mask_bits,
  output cau_pkg::elem_t                   result,
  output logic                             last
);
  import cau_pkg::*;

  localparam logic [HALF_W-1:0] HI_KEEP = (ELEM_BITS > HALF_W) ? '1 : '0;
  localparam logic [WIN_CMP_W-1:0] WIN_MAX = WIN_CMP_W'(MAX_WINDOW);

  elem_t              pend      [MAX_WINDOW];
  elem_t              pend_next [MAX_WINDOW];
  logic [LEN_W-1:0]   position;
  logic [LEN_W-1:0]   position_next;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   remain;
  logic [WIN_CMP_W-1:0] ws_ext;
  logic [WIN_CMP_W-1:0] win;

  always_comb begin
    ws_ext = WIN_CMP_W'(cfg.window_size);
    if (ws_ext < WINDOW_MIN)   win = WINDOW_MIN;
    else if (ws_ext > WIN_MAX) win = WIN_MAX;
    else                       win = ws_ext;
  end

  assign len    = (cfg.vector_length == '0) ? LENGTH_RESET : cfg.vector_length;
  assign last   = (position + LEN_W'(1)) >= len;
  // positions still ahead of this one; only meaningful when not last
  assign remain = len - position - LEN_W'(1);

  always_comb begin
    result     = elem ^ pend[0];
    result.hi  = result.hi  & HI_KEEP;
    result.hi2 = result.hi2 & HI_KEEP;
  end

  assign position_next = last ? '0 : position + LEN_W'(1);

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_entry
    logic  hit;
    logic  mbit;
    elem_t shifted;

    if (j < MASK_W) begin : g_m
      assign mbit = mask_bits[j];
    end else begin : g_nm
      assign mbit = 1'b0;
    end

    if (j + 1 < MAX_WINDOW) begin : g_sh
      assign shifted = pend[j+1];
    end else begin : g_top
      assign shifted = '0;
    end

    // entry j takes the result for offset j+1 from the current position
    assign hit = (WIN_CMP_W'(j + 1) <= win) && (LEN_W'(j + 1) <= remain) &&
                 ((WIN_CMP_W'(j + 1) == win) || mbit);

    always_comb begin
      if (last) pend_next[j] = '0;
      else      pend_next[j] = shifted ^ (hit ? result : '0);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pend[j] <= '0;
      end else if (take) begin
        pend[j] <= pend_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (take) begin
      position <= position_next;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/cau_checker.sv */
// Checker for the convolution accumulator unit: tracks the XOR window and compares results.
`timescale 1ns / 1ps

module cau_checker #(
  parameter int MAX_WINDOW = 32,
  parameter int ELEM_BITS  = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic                        pready,
  input  wire logic [cau_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cau_pkg::DATA_W-1:0]  pwdata,
  input  wire logic                        data_valid,
  input  wire logic                        data_ready,
  input  wire logic [cau_pkg::HALF_W-1:0]  data_lo,
  input  wire logic [cau_pkg::HALF_W-1:0]  data_hi,
  input  wire logic [cau_pkg::HALF_W-1:0]  data2_lo,
  input  wire logic [cau_pkg::HALF_W-1:0]  data2_hi,
  input  wire logic [cau_pkg::MASK_W-1:0]  mask_bits,
  input  wire logic                        result_valid,
  input  wire logic                        result_ready,
  input  wire logic [cau_pkg::HALF_W-1:0]  out_lo,
  input  wire logic [cau_pkg::HALF_W-1:0]  out_hi,
  input  wire logic [cau_pkg::HALF_W-1:0]  out2_lo,
  input  wire logic [cau_pkg::HALF_W-1:0]  out2_hi,
  input  wire logic                        is_last,
  output int                               fail_count,
  output int                               outstanding
);
  import cau_pkg::*;

  typedef struct packed {
    elem_t val;
    logic  last;
  } acc_out_t;

  // fwd_sum[d] holds the XOR still owed to the element d places ahead
  elem_t            fwd_sum [MAX_WINDOW];
  logic [WIN_REG_W-1:0] win_reg;
  logic [LEN_W-1:0] len_reg;
  logic [LEN_W-1:0] elem_pos;
  acc_out_t         predicted [$];
  acc_out_t         want;
  elem_t            raw_in;

  task automatic clear_sums();
    for (int d = 0; d < MAX_WINDOW; d++) fwd_sum[d] = '0;
  endtask

  task automatic fold_element(input elem_t raw, input logic [MASK_W-1:0] m);
    int reach;
    logic [LEN_W:0] len;
    logic [LEN_W:0] pos;
    acc_out_t r;
    reach = int'(win_reg);
    if (reach < 2) reach = 2;
    if (reach > MAX_WINDOW) reach = MAX_WINDOW;
    len = {1'b0, len_reg};
    if (len == 0) len = 1;
    pos = {1'b0, elem_pos};
    r.val = raw ^ fwd_sum[0];
    if (ELEM_BITS <= HALF_W) begin
      r.val.hi = '0;
      r.val.hi2 = '0;
    end
    r.last = (pos + 1 >= len);
    predicted = {predicted, r};
    if (r.last) begin
      elem_pos = '0;
      clear_sums();
    end else begin
      for (int d = 0; d < MAX_WINDOW - 1; d++) fwd_sum[d] = fwd_sum[d + 1];
      fwd_sum[MAX_WINDOW - 1] = '0;
      // contributions landing at or past the end of the vector are dropped
      for (int k = 1; k <= reach; k++) begin
        if (pos + k >= len) break;
        if (k == reach || (k - 1 < MASK_W && m[k - 1]))
          fwd_sum[k - 1] = fwd_sum[k - 1] ^ r.val;
      end
      elem_pos = pos[LEN_W-1:0] + 1'b1;
    end
  endtask

  task automatic flag_field(input string field, input logic [HALF_W-1:0] exp_v,
                            input logic [HALF_W-1:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h", field, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      win_reg = WINDOW_RESET;
      len_reg = LENGTH_RESET;
      elem_pos = '0;
      clear_sums();
      predicted.delete();
      fail_count = 0;
    end else begin
      // a transfer at this edge still sees the settings from before a write here
      if (data_valid && data_ready) begin
        raw_in.lo = data_lo;
        raw_in.hi = data_hi;
        raw_in.lo2 = data2_lo;
        raw_in.hi2 = data2_hi;
        fold_element(raw_in, mask_bits);
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_WINDOW_SIZE:   win_reg = pwdata[WIN_REG_W-1:0];
          REG_VECTOR_LENGTH: len_reg = pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (predicted.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result transfer with nothing expected: out_lo %h is_last %b",
                     out_lo, is_last);
        end else begin
          want = predicted.pop_front();
          if (out_lo !== want.val.lo) flag_field("out_lo", want.val.lo, out_lo);
          if (out_hi !== want.val.hi) flag_field("out_hi", want.val.hi, out_hi);
          if (out2_lo !== want.val.lo2) flag_field("out2_lo", want.val.lo2, out2_lo);
          if (out2_hi !== want.val.hi2) flag_field("out2_hi", want.val.hi2, out2_hi);
          if (is_last !== want.last)
            flag_field("is_last", HALF_W'(want.last), HALF_W'(is_last));
        end
      end
    end
    outstanding = predicted.size();
  end

endmodule

/* tb/sv/tb_convolution_accumulator_unit.sv */
// Testbench top for the convolution accumulator unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_convolution_accumulator_unit;
  import cau_pkg::*;

  localparam int MAX_WINDOW = 32;
  localparam int ELEM_BITS  = 128;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  wire  [DATA_W-1:0] prdata;
  wire               pready;
  logic              data_valid = 1'b0;
  wire               data_ready;
  logic [HALF_W-1:0] data_lo = '0;
  logic [HALF_W-1:0] data_hi = '0;
  logic [HALF_W-1:0] data2_lo = '0;
  logic [HALF_W-1:0] data2_hi = '0;
  logic [MASK_W-1:0] mask_bits = '0;
  wire               result_valid;
  logic              result_ready = 1'b0;
  wire  [HALF_W-1:0] out_lo;
  wire  [HALF_W-1:0] out_hi;
  wire  [HALF_W-1:0] out2_lo;
  wire  [HALF_W-1:0] out2_hi;
  wire               is_last;
  int                fail_count;
  int                outstanding;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int items_fed = 0;

  always #5 clk = ~clk;

  convolution_accumulator_unit #(
    .MAX_WINDOW(MAX_WINDOW),
    .ELEM_BITS(ELEM_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .data_valid(data_valid), .data_ready(data_ready),
    .data_lo(data_lo), .data_hi(data_hi), .data2_lo(data2_lo), .data2_hi(data2_hi),
    .mask_bits(mask_bits),
    .result_valid(result_valid), .result_ready(result_ready),
    .out_lo(out_lo), .out_hi(out_hi), .out2_lo(out2_lo), .out2_hi(out2_hi),
    .is_last(is_last)
  );

  cau_checker #(
    .MAX_WINDOW(MAX_WINDOW),
    .ELEM_BITS(ELEM_BITS)
  ) chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .data_valid(data_valid), .data_ready(data_ready),
    .data_lo(data_lo), .data_hi(data_hi), .data2_lo(data2_lo), .data2_hi(data2_hi),
    .mask_bits(mask_bits),
    .result_valid(result_valid), .result_ready(result_ready),
    .out_lo(out_lo), .out_hi(out_hi), .out2_lo(out2_lo), .out2_hi(out2_hi),
    .is_last(is_last),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // result side: a long hold-off takes priority over random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      result_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic elem_t rand_elem();
    elem_t e;
    int sel;
    sel = $urandom_range(19);
    e.lo = {$urandom, $urandom};
    e.hi = {$urandom, $urandom};
    e.lo2 = {$urandom, $urandom};
    e.hi2 = {$urandom, $urandom};
    if (sel == 0) begin
      e = '1;
    end else if (sel == 1) begin
      e = '0;
    end else if (sel < 5) begin
      // second vector unused
      e.lo2 = '0;
      e.hi2 = '0;
    end
    return e;
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    logic [MASK_W-1:0] m;
    int sel;
    sel = $urandom_range(9);
    m = MASK_W'($urandom);
    if (sel == 0) begin
      m = '0;
    end else if (sel == 1) begin
      m = '1;
    end else if (sel == 2) begin
      m = MASK_W'(1) << $urandom_range(MASK_W - 1);
    end
    return m;
  endfunction

  function automatic logic [WIN_REG_W-1:0] pick_window();
    logic [WIN_REG_W-1:0] w;
    int sel;
    sel = $urandom_range(9);
    w = WIN_REG_W'($urandom_range(3, MAX_WINDOW - 1));
    if (sel == 0) begin
      w = WIN_REG_W'(2);
    end else if (sel == 1) begin
      w = WIN_REG_W'(MAX_WINDOW);
    end else if (sel == 2) begin
      w = WIN_REG_W'($urandom_range(1));
    end else if (sel == 3) begin
      w = WIN_REG_W'($urandom_range(MAX_WINDOW + 1, 63));
    end
    return w;
  endfunction

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // entered and left at a falling edge
  task automatic feed_item(input elem_t e, input logic [MASK_W-1:0] m);
    if ($urandom_range(99) < send_idle_pct) begin
      data_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    data_valid = 1'b1;
    data_lo = e.lo;
    data_hi = e.hi;
    data2_lo = e.lo2;
    data2_hi = e.hi2;
    mask_bits = m;
    do @(posedge clk); while (!data_ready);
    items_fed++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    data_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [WIN_REG_W-1:0] w);
    logic [DATA_W-1:0] v;
    v = {DATA_W{1'b0}};
    if ($urandom_range(3) == 0) v = $urandom;
    v[WIN_REG_W-1:0] = w;
    write_reg(REG_WINDOW_SIZE, v);
  endtask

  // one vector, mostly whole; now and then reconfigured or cut short midway
  task automatic run_segment();
    int kind;
    int len;
    int part;
    kind = $urandom_range(9);
    drain_results();
    write_window(pick_window());
    if (kind == 0) begin
      len = ($urandom_range(3) == 0) ? 24'hFFFFFF : $urandom_range(100, 24'hFFFFFF);
      write_reg(REG_VECTOR_LENGTH, DATA_W'(len));
      part = $urandom_range(1, 30);
      repeat (part) feed_item(rand_elem(), rand_mask());
      drain_results();
      // new length at or below the current position ends the vector
      write_reg(REG_VECTOR_LENGTH, DATA_W'($urandom_range(1, part)));
      feed_item(rand_elem(), rand_mask());
    end else if (kind == 1) begin
      len = $urandom_range(4, 48);
      write_reg(REG_VECTOR_LENGTH, DATA_W'(len));
      part = $urandom_range(1, len - 1);
      repeat (part) feed_item(rand_elem(), rand_mask());
      drain_results();
      write_window(pick_window());
      repeat (len - part) feed_item(rand_elem(), rand_mask());
    end else begin
      len = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 48);
      write_reg(REG_VECTOR_LENGTH, DATA_W'(len));
      repeat ((len == 0) ? 1 : len) feed_item(rand_elem(), rand_mask());
    end
  endtask

  initial begin
    int send_pcts [4];
    int recv_pcts [4];
    int target;
    int wait_cnt;
    send_pcts = '{0, 75, 0, 8};
    recv_pcts = '{0, 0, 75, 8};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: every element is a vector of its own
    feed_item('1, '1);
    feed_item('0, '0);
    drain_results();
    write_reg(REG_WINDOW_SIZE, 32'd3);
    write_reg(REG_VECTOR_LENGTH, 32'd5);
    feed_item('1, '1);
    feed_item(rand_elem(), '0);
    feed_item(rand_elem(), 31'd1);
    feed_item(rand_elem(), 31'd2);
    feed_item(rand_elem(), rand_mask());
    // window above the maximum saturates, zero length acts as one
    drain_results();
    write_reg(REG_WINDOW_SIZE, 32'd63);
    write_reg(REG_VECTOR_LENGTH, 32'd0);
    feed_item(rand_elem(), '1);
    drain_results();
    write_reg(REG_VECTOR_LENGTH, 32'd40);
    repeat (3) feed_item(rand_elem(), rand_mask());
    // mid-vector: window below the minimum, then length lowered under position
    drain_results();
    write_reg(REG_WINDOW_SIZE, 32'd0);
    repeat (2) feed_item(rand_elem(), '1);
    drain_results();
    write_reg(REG_VECTOR_LENGTH, 32'd2);
    feed_item(rand_elem(), rand_mask());
    // vector shorter than the window
    drain_results();
    write_reg(REG_WINDOW_SIZE, 32'd8);
    write_reg(REG_VECTOR_LENGTH, 32'd3);
    repeat (3) feed_item(rand_elem(), '1);
    drain_results();
    write_reg(REG_WINDOW_SIZE, 32'd32);
    write_reg(REG_VECTOR_LENGTH, 32'hFFFFFF);
    repeat (4) feed_item(rand_elem(), '1);
    drain_results();
    write_reg(REG_VECTOR_LENGTH, 32'd1);
    feed_item('1, '1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      // long back-pressure while the sender keeps offering transfers
      if (ph == 0 || ph == 3) hold_cycles = 120;
      target = items_fed + 160;
      while (items_fed < target) run_segment();
    end

    data_valid = 1'b0;
    wait_cnt = 0;
    while (outstanding != 0 && wait_cnt < 20000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (4) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
